[sv/hdtu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hdtu_pkg;

    // Widths fixed by the register and field definitions
    localparam int TICK_W  = 19;
    localparam int BIT_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Transmit frame positions (bit_index values)
    localparam logic [BIT_W-1:0] TX_START_POS = 4'd0;
    localparam logic [BIT_W-1:0] TX_STOP_POS  = 4'd9;
    localparam logic [BIT_W-1:0] TX_DONE_POS  = 4'd10;
    // Receive: data bits before the stop bit
    localparam logic [BIT_W-1:0] RX_DATA_BITS = 4'd8;

    // Register indexes, decoded from paddr[2]
    localparam logic REG_BIT_TICKS      = 1'b0;
    localparam logic REG_CHANNEL_ENABLE = 1'b1;

    // Command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TX   = 2'd2
    } mode_t;

    typedef struct packed {
        logic              command;
        logic              rx_line;
        logic [BYTE_W-1:0] tx_data;
    } in_item_t;

    typedef struct packed {
        logic              tx_line;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_data;
        logic              frame_dropped;
        logic              send_accepted;
        logic [1:0]        line_state;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] bit_ticks;
        logic              channel_enable;
    } cfg_t;

    typedef struct packed {
        mode_t             mode;
        logic [TICK_W-1:0] tick_count;
        logic [BIT_W-1:0]  bit_index;
        logic [BYTE_W-1:0] tx_shift;
        logic [BYTE_W-1:0] rx_shift;
        logic              tx_level;
    } uart_state_t;

endpackage

`default_nettype wire

[sv/hdtu_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module hdtu_cfg
    import hdtu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    logic [TICK_W-1:0] bit_ticks_reg;
    logic              enable_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes on the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_ticks_reg <= '0;
            enable_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_BIT_TICKS:      bit_ticks_reg <= pwdata[TICK_W-1:0];
                REG_CHANNEL_ENABLE: enable_reg    <= pwdata[0];
                default:            ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (paddr[2])
            REG_BIT_TICKS:      prdata = {{(DATA_W-TICK_W){1'b0}}, bit_ticks_reg};
            REG_CHANNEL_ENABLE: prdata = {{(DATA_W-1){1'b0}}, enable_reg};
            default:            prdata = '0;
        endcase
    end

    assign cfg.bit_ticks      = bit_ticks_reg;
    assign cfg.channel_enable = enable_reg;

endmodule

`default_nettype wire

[sv/hdtu_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module hdtu_step
    import hdtu_pkg::*;
(
    input  wire uart_state_t cur,
    input  wire in_item_t    item,
    input  wire cfg_t        cfg,
    output uart_state_t      nxt,
    output out_item_t        res
);

    logic rx_good;
    logic rx_bad;
    logic sent;

    // Next state: send request, or tx side then rx side on an enabled tick
    always_comb
    begin
        uart_state_t s;
        logic        tx_end;
        logic        rx_end;
        s       = cur;
        rx_good = 1'b0;
        rx_bad  = 1'b0;
        sent    = 1'b0;
        tx_end  = 1'b0;
        rx_end  = 1'b0;
        if (item.command == CMD_SEND)
        begin
            if (cur.mode == MODE_IDLE)
            begin
                s.tx_shift  = item.tx_data;
                s.mode      = MODE_TX;
                s.bit_index = TX_START_POS;
                sent        = 1'b1;
            end
        end
        else if (cfg.channel_enable)
        begin
            // transmit side
            if (cur.mode == MODE_TX)
            begin
                tx_end = cur.tick_count >= cfg.bit_ticks;
                if (!tx_end)
                    s.tick_count = cur.tick_count + 1'b1;
                else
                begin
                    s.tick_count = '0;
                    if (cur.bit_index == TX_START_POS)
                    begin
                        s.tx_level  = 1'b0;
                        s.bit_index = cur.bit_index + 1'b1;
                    end
                    else if (cur.bit_index == TX_STOP_POS)
                    begin
                        s.tx_level  = 1'b1;
                        s.bit_index = TX_DONE_POS;
                    end
                    else if (cur.bit_index >= TX_DONE_POS)
                    begin
                        s.mode      = MODE_IDLE;
                        s.bit_index = '0;
                    end
                    else
                    begin
                        s.tx_level  = cur.tx_shift[cur.bit_index[2:0] - 3'd1];
                        s.bit_index = cur.bit_index + 1'b1;
                    end
                end
            end
            // receive side, sees the mode left by the transmit side
            if (s.mode == MODE_RX)
            begin
                rx_end = s.tick_count >= cfg.bit_ticks;
                if (!rx_end)
                    s.tick_count = s.tick_count + 1'b1;
                else
                begin
                    s.tick_count = '0;
                    if (s.bit_index >= RX_DATA_BITS)
                    begin
                        s.mode      = MODE_IDLE;
                        s.bit_index = '0;
                        rx_good     = item.rx_line;
                        rx_bad      = !item.rx_line;
                        s.rx_shift  = '0;
                    end
                    else
                    begin
                        s.rx_shift[s.bit_index[2:0]] = s.rx_shift[s.bit_index[2:0]]
                                                       | item.rx_line;
                        s.bit_index = s.bit_index + 1'b1;
                    end
                end
            end
            else if (s.mode == MODE_IDLE && !item.rx_line)
                s.mode = MODE_RX;
        end
        nxt = s;
    end

    // Result fields
    always_comb
    begin
        res.tx_line       = nxt.tx_level;
        res.rx_valid      = rx_good;
        res.rx_data       = rx_good ? cur.rx_shift : '0;
        res.frame_dropped = rx_bad;
        res.send_accepted = sent;
        res.line_state    = nxt.mode;
    end

endmodule

`default_nettype wire

[sv/hdtu_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

module hdtu_out_buf
    import hdtu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic           can_push,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_item_reg, out_item_next;
    out_item_t skid_item_reg, skid_item_next;
    logic      take;

    assign can_push  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign take      = out_valid_reg && out_ready;

    // Output register plus skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_item_next   = out_item_reg;
        skid_item_next  = skid_item_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_item_next  = push_item;
            end
        end
        else if (!out_valid_reg)
        begin
            out_valid_next = push;
            out_item_next  = push_item;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

`default_nettype wire

[sv/half_duplex_tick_uart.sv]
// Half-duplex 8N1 UART, one channel, stepped by tick and send transactions.
// Each result is registered, via the skid entry if the output is held.
// Throughput: one transaction per cycle while in_ready is high; one compare,
// one increment and a bit select lie between the state and result registers.
// Reset: line idle, transmit level high, counters, shifters and both
// configuration registers cleared; no result pending.
`timescale 1ns / 1ps
`default_nettype none

module half_duplex_tick_uart
    import hdtu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire in_item_t          in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready
);

    cfg_t        cfg;
    uart_state_t state_reg, state_next;
    out_item_t   step_res;
    logic        accept;

    assign accept = in_valid && in_ready;

    hdtu_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hdtu_step u_step (
        .cur  (state_reg),
        .item (in_data),
        .cfg  (cfg),
        .nxt  (state_next),
        .res  (step_res)
    );

    // UART state advances on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= MODE_IDLE;
            state_reg.tick_count <= '0;
            state_reg.bit_index  <= '0;
            state_reg.tx_shift   <= '0;
            state_reg.rx_shift   <= '0;
            state_reg.tx_level   <= 1'b1;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    hdtu_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (step_res),
        .can_push  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

endmodule

`default_nettype wire
